>>> sv/pfl_pkg.sv
package pfl_pkg;

  // field widths of the message stream
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned FIELD_W     = 29;
  localparam int unsigned WTYPE_W     = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OFS_W       = 32;
  localparam int unsigned VARINT_W    = 64;
  localparam int unsigned VCOUNT_W    = 4;
  localparam int unsigned SKIP_W      = 32;

  // varint and skip sizes
  localparam logic [VCOUNT_W-1:0] VARINT_MAX_BYTES = 4'd9;
  localparam logic [SKIP_W-1:0]   FIXED64_BYTES    = 32'd8;
  localparam logic [SKIP_W-1:0]   FIXED32_BYTES    = 32'd4;

  // reset value of the target field number
  localparam logic [FIELD_W-1:0]  TARGET_RESET     = 29'd1;

  // wire types that carry a skip
  localparam logic [WTYPE_W-1:0]  WT_VARINT  = 3'd0;
  localparam logic [WTYPE_W-1:0]  WT_FIXED64 = 3'd1;
  localparam logic [WTYPE_W-1:0]  WT_LEN     = 3'd2;
  localparam logic [WTYPE_W-1:0]  WT_FIXED32 = 3'd5;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_FOUND    = 2'd0,
    STATUS_PASSED   = 2'd1,
    STATUS_TOO_LONG = 2'd2,
    STATUS_ENDED    = 2'd3
  } status_e;

endpackage

>>> sv/pfl_byte_if.sv
interface pfl_byte_if;
  logic                           valid;
  logic                           ready;
  logic [pfl_pkg::DATA_W-1:0]     data_byte;
  logic                           last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> sv/pfl_result_if.sv
interface pfl_result_if;
  logic                           valid;
  logic                           ready;
  logic [pfl_pkg::STATUS_W-1:0]   status;
  logic [pfl_pkg::WTYPE_W-1:0]    wire_type;
  logic [pfl_pkg::OFS_W-1:0]      value_offset;

  modport source (output valid, output status, output wire_type, output value_offset,
                  input ready);
  modport sink   (input valid, input status, input wire_type, input value_offset,
                  output ready);
endinterface

>>> sv/pfl_cfg_if.sv
interface pfl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pfl_pkg::FIELD_W-1:0]    target_field;

  modport source (output valid, output target_field, input ready);
  modport sink   (input valid, input target_field, output ready);
endinterface

>>> sv/protobuf_field_locator.sv
// Scans a protobuf wire-format message one byte per cycle and reports one result item per
// message: found (with wire type and the offset of the first value byte), passed over, varint
// too long, or message ended. A byte is taken every cycle while the result register is empty
// or being drained; each byte updates the scan state in a single pass and a result is registered
// in the output register when its byte is taken. A result that is not taken stalls input until it
// is. Bytes after a result are counted but ignored; the byte marked last rearms the scanner.
// Write the target field number on the cfg channel only while idle; this is not enforced.
module protobuf_field_locator #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  pfl_byte_if.sink     byte_i,
  pfl_cfg_if.sink      cfg_i,
  pfl_result_if.source result_o
);

  localparam logic [1:0] MODE_KEY         = 2'd0;
  localparam logic [1:0] MODE_SKIP_VARINT = 2'd1;
  localparam logic [1:0] MODE_SKIP_LEN    = 2'd2;
  localparam logic [1:0] MODE_SKIP_BYTES  = 2'd3;

  logic [1:0]                         mode_q, mode_d;
  logic [pfl_pkg::VARINT_W-1:0]       acc_q, acc_d;
  logic [pfl_pkg::VCOUNT_W-1:0]       cnt_q, cnt_d;
  logic [pfl_pkg::SKIP_W-1:0]         skip_q, skip_d;
  logic [OFFSET_BITS-1:0]             pos_q, pos_d;
  logic                               answered_q, answered_d;
  logic [pfl_pkg::FIELD_W-1:0]        target_q;

  logic                               out_valid_q;
  logic [pfl_pkg::STATUS_W-1:0]       status_q, status_d;
  logic [pfl_pkg::WTYPE_W-1:0]        wtype_q, wtype_d;
  logic [pfl_pkg::OFS_W-1:0]          offset_q, offset_d;
  logic                               have;

  logic                               in_acc;
  logic [6:0]                         shamt;
  logic [pfl_pkg::VARINT_W-1:0]       acc_or;
  logic [pfl_pkg::VCOUNT_W-1:0]       cnt_inc;
  logic [pfl_pkg::VARINT_W-1:0]       pos_ext;
  logic [pfl_pkg::SKIP_W-1:0]         skip_dec;
  logic [31:0]                        key;
  logic [pfl_pkg::FIELD_W-1:0]        fnum;
  logic [pfl_pkg::WTYPE_W-1:0]        wt;

  // handshakes
  assign byte_i.ready = !out_valid_q || result_o.ready;
  assign cfg_i.ready  = 1'b1;
  assign in_acc       = byte_i.valid && byte_i.ready;

  // varint datapath
  assign shamt    = 7'(cnt_q) * 7'd7;
  assign acc_or   = acc_q | ({57'd0, byte_i.data_byte[6:0]} << shamt[5:0]);
  assign cnt_inc  = cnt_q + 4'd1;
  assign key      = acc_or[31:0];
  assign fnum     = key[31:3];
  assign wt       = key[2:0];
  assign skip_dec = (skip_q != '0) ? skip_q - 32'd1 : skip_q;
  assign pos_d    = pos_q + 1'b1;
  assign pos_ext  = 64'(pos_d);

  // scan state update for one byte
  always_comb begin
    mode_d     = mode_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    skip_d     = skip_q;
    answered_d = answered_q;
    have       = 1'b0;
    status_d   = pfl_pkg::STATUS_FOUND;
    wtype_d    = '0;
    offset_d   = '0;
    if (!answered_q) begin
      if (mode_q == MODE_SKIP_BYTES) begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          mode_d = MODE_KEY;
        end
      end else if (byte_i.data_byte[7]) begin
        acc_d = acc_or;
        cnt_d = cnt_inc;
        if (cnt_inc >= pfl_pkg::VARINT_MAX_BYTES) begin
          have     = 1'b1;
          status_d = pfl_pkg::STATUS_TOO_LONG;
        end
      end else begin
        acc_d = '0;
        cnt_d = '0;
        case (mode_q)
          MODE_KEY: begin
            if (fnum < target_q) begin
              case (wt)
                pfl_pkg::WT_VARINT: mode_d = MODE_SKIP_VARINT;
                pfl_pkg::WT_FIXED64: begin
                  skip_d = pfl_pkg::FIXED64_BYTES;
                  mode_d = MODE_SKIP_BYTES;
                end
                pfl_pkg::WT_LEN: mode_d = MODE_SKIP_LEN;
                pfl_pkg::WT_FIXED32: begin
                  skip_d = pfl_pkg::FIXED32_BYTES;
                  mode_d = MODE_SKIP_BYTES;
                end
                default: mode_d = MODE_KEY;
              endcase
            end else if (fnum == target_q) begin
              have     = 1'b1;
              status_d = pfl_pkg::STATUS_FOUND;
              wtype_d  = wt;
              offset_d = pos_ext[31:0];
            end else begin
              have     = 1'b1;
              status_d = pfl_pkg::STATUS_PASSED;
            end
          end
          MODE_SKIP_LEN: begin
            // saturate lengths above 32 bits
            if (acc_or[63:32] != '0) begin
              skip_d = '1;
              mode_d = MODE_SKIP_BYTES;
            end else if (acc_or[31:0] == '0) begin
              mode_d = MODE_KEY;
            end else begin
              skip_d = acc_or[31:0];
              mode_d = MODE_SKIP_BYTES;
            end
          end
          default: mode_d = MODE_KEY;
        endcase
      end
    end
    // end of message rearms the scanner
    if (byte_i.last_byte) begin
      if (!have && !answered_q) begin
        have     = 1'b1;
        status_d = pfl_pkg::STATUS_ENDED;
      end
      mode_d     = MODE_KEY;
      acc_d      = '0;
      cnt_d      = '0;
      skip_d     = '0;
      answered_d = 1'b0;
    end else if (have) begin
      answered_d = 1'b1;
    end
  end

  // scan state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_KEY;
      acc_q      <= '0;
      cnt_q      <= '0;
      skip_q     <= '0;
      pos_q      <= '0;
      answered_q <= 1'b0;
    end else if (in_acc) begin
      mode_q     <= mode_d;
      acc_q      <= acc_d;
      cnt_q      <= cnt_d;
      skip_q     <= skip_d;
      pos_q      <= byte_i.last_byte ? '0 : pos_d;
      answered_q <= answered_d;
    end
  end

  // target register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= pfl_pkg::TARGET_RESET;
    end else if (cfg_i.valid) begin
      target_q <= cfg_i.target_field;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && have) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && have) begin
      status_q <= status_d;
      wtype_q  <= wtype_d;
      offset_q <= offset_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.status       = status_q;
  assign result_o.wire_type    = wtype_q;
  assign result_o.value_offset = offset_q;

  // a waiting result blocks new bytes
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready |-> !byte_i.ready)
    else $error("byte accepted while result is stalled");

  // the last byte rearms the scanner
  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && byte_i.last_byte |=> !answered_q && pos_q == '0 && cnt_q == '0)
    else $error("scanner not rearmed after last byte");

  // varint byte count never passes the limit
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pfl_pkg::VARINT_MAX_BYTES)
    else $error("varint byte count out of range");

  // only a found result carries wire type and offset
  a_found_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != pfl_pkg::STATUS_FOUND |-> wtype_q == '0 && offset_q == '0)
    else $error("payload on a non-found result");

endmodule

>>> verif/testbench.sv
module testbench;
  import pfl_pkg::*;

  localparam logic [FIELD_W-1:0] FIELD_MAX       = '1;
  localparam logic [WTYPE_W-1:0] WT_START_GROUP  = 3'd3;
  localparam logic [WTYPE_W-1:0] WT_END_GROUP    = 3'd4;
  localparam logic [WTYPE_W-1:0] WT_RESERVED_6   = 3'd6;
  localparam logic [WTYPE_W-1:0] WT_RESERVED_7   = 3'd7;
  localparam int                 BYTES_PER_PHASE = 230;
  localparam int                 HOLD_CYCLES     = 300;
  localparam int                 SETTLE_CYCLES   = 4;

  typedef enum logic [1:0] {
    SCAN_KEY,
    SCAN_SKIP_VARINT,
    SCAN_SKIP_LEN,
    SCAN_SKIP_BYTES
  } scan_mode_e;

  typedef struct packed {
    status_e              status;
    logic [WTYPE_W-1:0]   wire_type;
    logic [OFS_W-1:0]     value_offset;
  } locate_result_t;

  // shadow scanner plus the queue of locate results still owed by the block
  class locate_board;
    logic [FIELD_W-1:0]   target;
    scan_mode_e           mode;
    logic [VARINT_W-1:0]  accum;
    logic [VCOUNT_W-1:0]  vbytes;
    logic [SKIP_W-1:0]    skip_left;
    logic [OFS_W-1:0]     position;
    bit                   answered;
    locate_result_t       owed_results[$];
    int                   errors;

    function new();
      target = TARGET_RESET;
      errors = 0;
      rearm();
    endfunction

    function void rearm();
      mode      = SCAN_KEY;
      accum     = '0;
      vbytes    = '0;
      skip_left = '0;
      position  = '0;
      answered  = 1'b0;
    endfunction

    function void set_target(logic [FIELD_W-1:0] value);
      target = value;
    endfunction

    function int pending_count();
      return owed_results.size();
    endfunction

    // advance the scan by one accepted byte
    function void take_byte(logic [DATA_W-1:0] data, logic last);
      bit                  have;
      locate_result_t      res;
      logic [VARINT_W-1:0] value;
      logic [31:0]         key;
      have     = 1'b0;
      res      = '0;
      position = position + 1'b1;
      if (!answered) begin
        if (mode == SCAN_SKIP_BYTES) begin
          if (skip_left != 0) skip_left = skip_left - 1'b1;
          if (skip_left == 0) mode = SCAN_KEY;
        end else begin
          accum  = accum | ({57'd0, data[6:0]} << (7 * vbytes));
          vbytes = vbytes + 1'b1;
          if (data[7]) begin
            if (vbytes >= VARINT_MAX_BYTES) begin
              have       = 1'b1;
              res.status = STATUS_TOO_LONG;
            end
          end else begin
            value  = accum;
            accum  = '0;
            vbytes = '0;
            case (mode)
              SCAN_KEY: begin
                key = value[31:0];
                if (key[31:3] < target) begin
                  case (key[2:0])
                    WT_VARINT:  mode = SCAN_SKIP_VARINT;
                    WT_FIXED64: begin
                      skip_left = FIXED64_BYTES;
                      mode      = SCAN_SKIP_BYTES;
                    end
                    WT_LEN:     mode = SCAN_SKIP_LEN;
                    WT_FIXED32: begin
                      skip_left = FIXED32_BYTES;
                      mode      = SCAN_SKIP_BYTES;
                    end
                    default: ;
                  endcase
                end else if (key[31:3] == target) begin
                  have             = 1'b1;
                  res.status       = STATUS_FOUND;
                  res.wire_type    = key[2:0];
                  res.value_offset = position;
                end else begin
                  have       = 1'b1;
                  res.status = STATUS_PASSED;
                end
              end
              SCAN_SKIP_LEN: begin
                // lengths beyond 32 bits saturate
                if (value[63:32] != 0) skip_left = '1;
                else skip_left = value[31:0];
                mode = (skip_left == 0) ? SCAN_KEY : SCAN_SKIP_BYTES;
              end
              default: mode = SCAN_KEY;
            endcase
          end
        end
      end
      if (last) begin
        if (!have && !answered) begin
          have       = 1'b1;
          res.status = STATUS_ENDED;
        end
        rearm();
      end else if (have) begin
        answered = 1'b1;
      end
      if (have) owed_results.push_back(res);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [WTYPE_W-1:0] wire_type,
                               logic [OFS_W-1:0] value_offset);
      locate_result_t want;
      if (owed_results.size() == 0) begin
        $error("result item with none owed: status %0d", status);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (status !== want.status) begin
        $error("status mismatch: expected %0d actual %0d", want.status, status);
        errors++;
      end
      if (wire_type !== want.wire_type) begin
        $error("wire_type mismatch: expected %0d actual %0d", want.wire_type, wire_type);
        errors++;
      end
      if (value_offset !== want.value_offset) begin
        $error("value_offset mismatch: expected %0d actual %0d", want.value_offset,
               value_offset);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  pfl_byte_if   byte_if ();
  pfl_cfg_if    cfg_if ();
  pfl_result_if result_if ();

  protobuf_field_locator #(
    .OFFSET_BITS(32)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .cfg_i    (cfg_if),
    .result_o (result_if)
  );

  locate_board          board;
  logic [DATA_W-1:0]    msg_bytes[$];
  int                   send_idle_pct  = 0;
  int                   recv_stall_pct = 0;
  int                   hold_cycles    = 0;

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    result_if.ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // long hold-off countdown
  always @(posedge clk_i) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // watch accepted items on every channel
  always @(posedge clk_i) begin
    if (cfg_if.valid && cfg_if.ready) board.set_target(cfg_if.target_field);
    if (byte_if.valid && byte_if.ready) board.take_byte(byte_if.data_byte, byte_if.last_byte);
    if (result_if.valid && result_if.ready) begin
      board.check_result(result_if.status, result_if.wire_type, result_if.value_offset);
    end
  end

  // message building
  function automatic void add_varint(logic [VARINT_W-1:0] value);
    logic [VARINT_W-1:0] rest;
    rest = value;
    do begin
      msg_bytes.push_back({(rest >> 7) != 0, rest[6:0]});
      rest = rest >> 7;
    end while (rest != 0);
  endfunction

  function automatic logic [VARINT_W-1:0] rand_varint_value();
    return {$urandom, $urandom} & ((64'd1 << $urandom_range(1, 63)) - 1'b1);
  endfunction

  function automatic void add_overlong();
    repeat (9) msg_bytes.push_back(8'h80 | 8'($urandom));
  endfunction

  function automatic void add_key(logic [FIELD_W-1:0] fnum, logic [WTYPE_W-1:0] wt);
    logic [VARINT_W-1:0] key;
    key = {32'd0, fnum, wt};
    // sometimes junk above bit 31 that the scanner must drop
    if ($urandom_range(7) == 0) key[62:32] = 31'($urandom);
    add_varint(key);
  endfunction

  function automatic logic [WTYPE_W-1:0] skip_type();
    if ($urandom_range(99) < 85) begin
      case ($urandom_range(3))
        0:       return WT_VARINT;
        1:       return WT_FIXED64;
        2:       return WT_LEN;
        default: return WT_FIXED32;
      endcase
    end
    case ($urandom_range(3))
      0:       return WT_START_GROUP;
      1:       return WT_END_GROUP;
      2:       return WT_RESERVED_6;
      default: return WT_RESERVED_7;
    endcase
  endfunction

  function automatic void add_body(logic [WTYPE_W-1:0] wt);
    int pick;
    int n;
    pick = $urandom_range(99);
    case (wt)
      WT_VARINT: begin
        if (pick < 5) add_overlong();
        else add_varint(rand_varint_value());
      end
      WT_FIXED64: repeat (FIXED64_BYTES) msg_bytes.push_back(8'($urandom));
      WT_FIXED32: repeat (FIXED32_BYTES) msg_bytes.push_back(8'($urandom));
      WT_LEN: begin
        if (pick < 10) begin
          add_varint('0);
        end else if (pick < 18) begin
          // length past 32 bits, message ends inside the skip
          add_varint({8'd0, 24'($urandom_range(1, 255)), $urandom});
        end else begin
          n = $urandom_range(1, 6);
          add_varint(64'(n));
          repeat (n) msg_bytes.push_back(8'($urandom));
        end
      end
      default: ;
    endcase
  endfunction

  // mostly well-formed messages, some pure noise
  function automatic void build_message(logic [FIELD_W-1:0] target);
    int                 nfields;
    int                 ending;
    logic [WTYPE_W-1:0] wt;
    msg_bytes.delete();
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
      return;
    end
    nfields = (target == 0) ? 0 : $urandom_range(4);
    repeat (nfields) begin
      wt = skip_type();
      add_key(FIELD_W'($urandom % target), wt);
      add_body(wt);
    end
    ending = $urandom_range(99);
    if (ending < 50 || (ending < 70 && target == FIELD_MAX)) begin
      add_key(target, WTYPE_W'($urandom));
    end else if (ending < 70) begin
      add_key(target + 1'b1 + FIELD_W'($urandom % (FIELD_MAX - target)), WTYPE_W'($urandom));
    end else if (ending < 82) begin
      add_overlong();
    end else begin
      // cut off inside a key
      repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'h80 | 8'($urandom));
    end
    // bytes after a result are ignored up to the end marker
    if (ending < 82) repeat ($urandom_range(3)) msg_bytes.push_back(8'($urandom));
  endfunction

  // drivers
  task automatic push_byte(logic [DATA_W-1:0] data, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= data;
    byte_if.last_byte <= last;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) push_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  task automatic drain();
    byte_if.valid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_target(logic [FIELD_W-1:0] value);
    cfg_if.valid        <= 1'b1;
    cfg_if.target_field <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(logic [FIELD_W-1:0] target, int idle_pct, int stall_pct, bit hold);
    int sent;
    write_target(target);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold) hold_cycles <= HOLD_CYCLES;
    sent = 0;
    while (sent < BYTES_PER_PHASE) begin
      build_message(target);
      sent += msg_bytes.size();
      send_message();
    end
    drain();
  endtask

  initial begin
    board                = new();
    rst_ni               = 1'b0;
    byte_if.valid        = 1'b0;
    byte_if.data_byte    = '0;
    byte_if.last_byte    = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.target_field  = '0;
    result_if.ready      = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // target 1 from reset: zero length skip, found on fixed32 key, trailing byte ignored
    msg_bytes = '{8'h02, 8'h00, 8'h0D, 8'h55};
    send_message();
    // higher field passed over on the final byte
    msg_bytes = '{8'h10};
    send_message();
    // over-long key varint
    msg_bytes = '{8'h80, 8'hFF, 8'h80, 8'hFF, 8'h80, 8'hFF, 8'h80, 8'hFF, 8'hFF};
    send_message();
    // unknown wire type skips nothing, found on the final byte
    msg_bytes = '{8'h03, 8'h08};
    send_message();
    // message ends inside a fixed64 skip
    msg_bytes = '{8'h01, 8'hAA};
    send_message();
    drain();

    // top field number with a key wider than 32 bits
    write_target(FIELD_MAX);
    msg_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01};
    send_message();
    drain();

    run_phase('0, 0, 0, 1'b0);
    run_phase(FIELD_W'($urandom_range(1, 30)), 57, 0, 1'b0);
    run_phase(FIELD_MAX, 0, 57, 1'b0);
    run_phase(FIELD_W'($urandom), 35, 35, 1'b0);
    run_phase(FIELD_W'($urandom_range(1, 12)), 0, 0, 1'b1);

    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
